FILE: hdl/ptd_pkg.sv
`default_nettype none
package ptd_pkg;

    localparam int INDEX_BITS_DEF  = 24;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int THRESHOLD_BITS  = 16;

    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 16'd100;

    localparam logic KIND_PEAK   = 1'b0;
    localparam logic KIND_TROUGH = 1'b1;

    typedef enum logic [2:0] {
        MODE_UNDECIDED = 3'b001,
        MODE_PEAK      = 3'b010,
        MODE_TROUGH    = 3'b100
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  ev_valid;
        logic  ev_kind;
    } ptd_ctrl_t;

endpackage
`default_nettype wire

FILE: hdl/ptd_core.sv
`default_nettype none
module ptd_core #(
    parameter int INDEX_BITS  = ptd_pkg::INDEX_BITS_DEF,
    parameter int SAMPLE_BITS = ptd_pkg::SAMPLE_BITS_DEF
) (
    input  wire ptd_pkg::mode_t                    cur_mode,
    input  wire logic signed [SAMPLE_BITS-1:0]     cur_max_value,
    input  wire logic [INDEX_BITS-1:0]             cur_max_index,
    input  wire logic signed [SAMPLE_BITS-1:0]     cur_min_value,
    input  wire logic [INDEX_BITS-1:0]             cur_min_index,
    input  wire logic [INDEX_BITS-1:0]             cur_sample_index,
    input  wire logic [INDEX_BITS-1:0]             cur_peak_count,
    input  wire logic [INDEX_BITS-1:0]             cur_trough_count,
    input  wire logic signed [SAMPLE_BITS-1:0]     sample,
    input  wire logic                              last_sample,
    input  wire logic [ptd_pkg::THRESHOLD_BITS-1:0] threshold,
    output ptd_pkg::ptd_ctrl_t                     ctrl,
    output logic signed [SAMPLE_BITS-1:0]          nxt_max_value,
    output logic [INDEX_BITS-1:0]                  nxt_max_index,
    output logic signed [SAMPLE_BITS-1:0]          nxt_min_value,
    output logic [INDEX_BITS-1:0]                  nxt_min_index,
    output logic [INDEX_BITS-1:0]                  nxt_sample_index,
    output logic [INDEX_BITS-1:0]                  nxt_peak_count,
    output logic [INDEX_BITS-1:0]                  nxt_trough_count,
    output logic [INDEX_BITS-1:0]                  ev_index,
    output logic [INDEX_BITS-1:0]                  ev_count
);
    import ptd_pkg::*;

    localparam int CMP_BITS = ((SAMPLE_BITS > THRESHOLD_BITS) ? SAMPLE_BITS
                                                              : THRESHOLD_BITS) + 2;

    logic                          first;
    logic signed [SAMPLE_BITS-1:0] mx;
    logic signed [SAMPLE_BITS-1:0] mn;
    logic [INDEX_BITS-1:0]         mxi;
    logic [INDEX_BITS-1:0]         mni;
    logic signed [CMP_BITS-1:0]    x_w;
    logic signed [CMP_BITS-1:0]    e_w;
    logic signed [CMP_BITS-1:0]    x_plus_e;
    logic signed [CMP_BITS-1:0]    mn_plus_e;
    logic                          drop;
    logic                          rise;
    logic                          max_le_x;
    logic                          x_le_min;

    function automatic logic [INDEX_BITS-1:0] sat_inc(input logic [INDEX_BITS-1:0] v);
        return (&v) ? v : v + INDEX_BITS'(1);
    endfunction

    // Load the extremes from the first sample of a record before comparing
    assign first = (cur_sample_index == '0);
    assign mx    = first ? sample : cur_max_value;
    assign mn    = first ? sample : cur_min_value;
    assign mxi   = first ? '0 : cur_max_index;
    assign mni   = first ? '0 : cur_min_index;

    assign x_w       = CMP_BITS'(sample);
    assign e_w       = $signed({{(CMP_BITS-THRESHOLD_BITS){1'b0}}, threshold});
    assign x_plus_e  = x_w + e_w;
    assign mn_plus_e = CMP_BITS'(mn) + e_w;
    assign drop      = (CMP_BITS'(mx) >= x_plus_e);
    assign rise      = (x_w >= mn_plus_e);
    assign max_le_x  = (mx <= sample);
    assign x_le_min  = (sample <= mn);

    always_comb begin
        ctrl.mode        = cur_mode;
        ctrl.ev_valid    = 1'b0;
        ctrl.ev_kind     = KIND_PEAK;
        nxt_max_value    = mx;
        nxt_max_index    = mxi;
        nxt_min_value    = mn;
        nxt_min_index    = mni;
        nxt_peak_count   = cur_peak_count;
        nxt_trough_count = cur_trough_count;
        ev_index         = mxi;
        ev_count         = cur_peak_count;

        case (cur_mode)
            MODE_PEAK: begin
                if (max_le_x) begin
                    nxt_max_value = sample;
                    nxt_max_index = cur_sample_index;
                end else if (drop) begin
                    nxt_peak_count = sat_inc(cur_peak_count);
                    ctrl.ev_valid  = 1'b1;
                    ctrl.ev_kind   = KIND_PEAK;
                    ev_index       = mxi;
                    ev_count       = nxt_peak_count;
                    nxt_min_value  = sample;
                    nxt_min_index  = cur_sample_index;
                    ctrl.mode      = MODE_TROUGH;
                end
            end
            MODE_TROUGH: begin
                if (x_le_min) begin
                    nxt_min_value = sample;
                    nxt_min_index = cur_sample_index;
                end else if (rise) begin
                    nxt_trough_count = sat_inc(cur_trough_count);
                    ctrl.ev_valid    = 1'b1;
                    ctrl.ev_kind     = KIND_TROUGH;
                    ev_index         = mni;
                    ev_count         = nxt_trough_count;
                    nxt_max_value    = sample;
                    nxt_max_index    = cur_sample_index;
                    ctrl.mode        = MODE_PEAK;
                end
            end
            default: begin
                // Undecided: pick a direction first, then widen the range
                if (drop) begin
                    ctrl.mode = MODE_TROUGH;
                end else if (rise) begin
                    ctrl.mode = MODE_PEAK;
                end
                if (max_le_x) begin
                    nxt_max_value = sample;
                    nxt_max_index = cur_sample_index;
                end else if (x_le_min) begin
                    nxt_min_value = sample;
                    nxt_min_index = cur_sample_index;
                end
            end
        endcase

        nxt_sample_index = sat_inc(cur_sample_index);

        // Drop the record state after its final sample
        if (last_sample) begin
            ctrl.mode        = MODE_UNDECIDED;
            nxt_max_value    = '0;
            nxt_max_index    = '0;
            nxt_min_value    = '0;
            nxt_min_index    = '0;
            nxt_sample_index = '0;
            nxt_peak_count   = '0;
            nxt_trough_count = '0;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/peak_trough_hysteresis_detector.sv
`default_nettype none
// Peak and trough detector with hysteresis. Each input beat carries one signed
// sample and a last_sample flag; the block keeps the running maximum and minimum
// of the record and reports a peak once a sample falls at least threshold below
// the maximum, or a trough once one rises at least threshold above the minimum.
// A result beat carries the kind, the index of the confirmed extreme and the
// saturating count of events of that kind. One sample is taken every cycle while
// the m_ side keeps up, and its result, if any, appears on the m_ side in the
// cycle after acceptance: the whole update is a single pass of compares and adds
// from the state registers. A result that waits in the output register holds off
// the s_ side; the register takes the next sample in the same cycle that its
// result is taken, so samples and results can flow back to back.
// The threshold register is written through cfg_we/cfg_wdata; the user must write
// it only while idle, as the block itself does not enforce this. It resets to 100. A
// last_sample beat is processed normally and then the record state restarts.
module peak_trough_hysteresis_detector #(
    parameter int INDEX_BITS  = ptd_pkg::INDEX_BITS_DEF,
    parameter int SAMPLE_BITS = ptd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [ptd_pkg::THRESHOLD_BITS-1:0] cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]      s_sample,
    input  wire logic                               s_last_sample,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_event_kind,
    output logic [INDEX_BITS-1:0]                   m_event_index,
    output logic [INDEX_BITS-1:0]                   m_event_count
);
    import ptd_pkg::*;

    // Threshold register
    logic [THRESHOLD_BITS-1:0]     threshold_reg;

    // Record state
    mode_t                         mode_reg;
    logic signed [SAMPLE_BITS-1:0] max_value_reg;
    logic [INDEX_BITS-1:0]         max_index_reg;
    logic signed [SAMPLE_BITS-1:0] min_value_reg;
    logic [INDEX_BITS-1:0]         min_index_reg;
    logic [INDEX_BITS-1:0]         sample_index_reg;
    logic [INDEX_BITS-1:0]         peak_count_reg;
    logic [INDEX_BITS-1:0]         trough_count_reg;

    // Next values from the update logic
    ptd_ctrl_t                     ctrl_next;
    logic signed [SAMPLE_BITS-1:0] max_value_next;
    logic [INDEX_BITS-1:0]         max_index_next;
    logic signed [SAMPLE_BITS-1:0] min_value_next;
    logic [INDEX_BITS-1:0]         min_index_next;
    logic [INDEX_BITS-1:0]         sample_index_next;
    logic [INDEX_BITS-1:0]         peak_count_next;
    logic [INDEX_BITS-1:0]         trough_count_next;
    logic [INDEX_BITS-1:0]         ev_index_next;
    logic [INDEX_BITS-1:0]         ev_count_next;

    // Result register
    logic                          m_valid_reg;
    logic                          m_event_kind_reg;
    logic [INDEX_BITS-1:0]         m_event_index_reg;
    logic [INDEX_BITS-1:0]         m_event_count_reg;

    logic                          s_accept;

    // Take a new beat whenever the result register is empty or being drained
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
        end else if (cfg_we) begin
            threshold_reg <= cfg_wdata;
        end
    end

    ptd_core #(
        .INDEX_BITS  (INDEX_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .cur_mode         (mode_reg),
        .cur_max_value    (max_value_reg),
        .cur_max_index    (max_index_reg),
        .cur_min_value    (min_value_reg),
        .cur_min_index    (min_index_reg),
        .cur_sample_index (sample_index_reg),
        .cur_peak_count   (peak_count_reg),
        .cur_trough_count (trough_count_reg),
        .sample           (s_sample),
        .last_sample      (s_last_sample),
        .threshold        (threshold_reg),
        .ctrl             (ctrl_next),
        .nxt_max_value    (max_value_next),
        .nxt_max_index    (max_index_next),
        .nxt_min_value    (min_value_next),
        .nxt_min_index    (min_index_next),
        .nxt_sample_index (sample_index_next),
        .nxt_peak_count   (peak_count_next),
        .nxt_trough_count (trough_count_next),
        .ev_index         (ev_index_next),
        .ev_count         (ev_count_next)
    );

    // Advance the record state on every accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_UNDECIDED;
            max_value_reg    <= '0;
            max_index_reg    <= '0;
            min_value_reg    <= '0;
            min_index_reg    <= '0;
            sample_index_reg <= '0;
            peak_count_reg   <= '0;
            trough_count_reg <= '0;
        end else if (s_accept) begin
            mode_reg         <= ctrl_next.mode;
            max_value_reg    <= max_value_next;
            max_index_reg    <= max_index_next;
            min_value_reg    <= min_value_next;
            min_index_reg    <= min_index_next;
            sample_index_reg <= sample_index_next;
            peak_count_reg   <= peak_count_next;
            trough_count_reg <= trough_count_next;
        end
    end

    // Result valid: set by an accepted beat that confirms an event, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= ctrl_next.ev_valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload: load only with a new event, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_accept && ctrl_next.ev_valid) begin
            m_event_kind_reg  <= ctrl_next.ev_kind;
            m_event_index_reg <= ev_index_next;
            m_event_count_reg <= ev_count_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_event_kind  = m_event_kind_reg;
    assign m_event_index = m_event_index_reg;
    assign m_event_count = m_event_count_reg;

endmodule
`default_nettype wire
